### src/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// Types, codes and priority scan functions shared by the interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

   // operation codes
   localparam logic [2:0] OP_IO_READ       = 3'd0;
   localparam logic [2:0] OP_IO_WRITE      = 3'd1;
   localparam logic [2:0] OP_LINE_ASSERT   = 3'd2;
   localparam logic [2:0] OP_ASSERT_NOTIFY = 3'd3;
   localparam logic [2:0] OP_LINE_DEASSERT = 3'd4;
   localparam logic [2:0] OP_CPU_ACK       = 3'd5;
   localparam logic [2:0] OP_CASCADE_ACK   = 3'd6;
   localparam logic [2:0] OP_NONE          = 3'd7;

   // port selects
   localparam logic [1:0] PORT_CMD  = 2'd0;
   localparam logic [1:0] PORT_DATA = 2'd1;
   localparam logic [1:0] PORT_ELCR = 2'd2;
   localparam logic [1:0] PORT_NONE = 2'd3;

   // ICW1 bits
   localparam int INIT1_HAS_W4 = 0;
   localparam int INIT1_SINGLE = 1;
   localparam int INIT1_LEVEL  = 3;
   localparam int INIT1_START  = 4;

   // ICW4 bits
   localparam int INIT4_AUTO_EOI = 1;
   localparam int INIT4_MASTER   = 2;
   localparam int INIT4_BUFFERED = 3;
   localparam int INIT4_NESTED   = 4;

   // OCW2 / OCW3 bits
   localparam int OCW3_RIS  = 0;
   localparam int OCW3_RR   = 1;
   localparam int OCW3_POLL = 2;
   localparam int OCW_SEL3  = 3;
   localparam int OCW3_SMM  = 5;
   localparam int OCW2_EOI  = 5;
   localparam int OCW2_SL   = 6;
   localparam int OCW3_ESMM = 6;
   localparam int OCW2_ROT  = 7;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] port_sel;
      logic [7:0] wdata;
      logic [2:0] line;
      logic [2:0] cascade_id;
   } pic_req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       handled;
      logic       int_level;
      logic       cascade_request;
      logic [2:0] cascade_line;
      logic [7:0] notify_bits;
   } pic_rsp_type;

   typedef struct packed {
      logic       found;
      logic [2:0] idx;
   } pic_scan_type;

   // first set bit in rotating order, starting just above the lowest level
   function automatic pic_scan_type first_hit(input logic [7:0] vec,
                                              input logic [2:0] lowest);
      pic_scan_type r;
      logic [2:0]   lv;
      r.found = 1'b0;
      r.idx   = lowest;
      for (int i = 0; i < 8; i++) begin
         lv = lowest + 3'(i + 1);
         if (!r.found && vec[lv]) begin
            r.found = 1'b1;
            r.idx   = lv;
         end
      end
      return r;
   endfunction

   // priority resolver: an in-service level blocks lower ones
   function automatic pic_scan_type prio_scan(input logic [7:0] requests,
                                              input logic [7:0] mask,
                                              input logic [7:0] in_service,
                                              input logic [7:0] cascade_word,
                                              input logic       nested,
                                              input logic       smm,
                                              input logic [2:0] lowest);
      logic [7:0]   blocked;
      logic [7:0]   pending;
      pic_scan_type h;
      pic_scan_type r;
      blocked = smm ? 8'h00 : (in_service & ~(nested ? cascade_word : 8'h00));
      pending = requests & ~mask;
      h       = first_hit(blocked | pending, lowest);
      r.idx   = h.idx;
      r.found = h.found & pending[h.idx] & ~blocked[h.idx];
      return r;
   endfunction

endpackage

### src/pic_in_stage.sv
// ----------------------------------------------------------------------------
// pic_in_stage
// Input register holding one request ahead of the controller core.
// ----------------------------------------------------------------------------
module pic_in_stage
   import pic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        s_valid,
   output logic        s_ready,
   input  pic_req_type s_item,
   input  logic        advance,
   output logic        m_valid,
   output pic_req_type m_item
);

   logic        valid_ff;
   logic        valid_in;
   pic_req_type item_ff;
   logic        accept;

   assign s_ready  = !valid_ff || advance;
   assign accept   = s_valid && s_ready;
   assign valid_in = accept ? 1'b1 : (advance ? 1'b0 : valid_ff);
   assign m_valid  = valid_ff;
   assign m_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= s_item;
      end
   end

endmodule

### src/pic_engine.sv
// ----------------------------------------------------------------------------
// pic_engine
// Controller state and the single-pass update for one request.
// ----------------------------------------------------------------------------
module pic_engine
   import pic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_wdata,
   input  logic        step_en,
   input  pic_req_type item,
   output pic_rsp_type step_rsp
);

   localparam logic [1:0] PHASE_MASK = 2'd0;
   localparam logic [1:0] PHASE_ICW2 = 2'd1;
   localparam logic [1:0] PHASE_ICW3 = 2'd2;
   localparam logic [1:0] PHASE_ICW4 = 2'd3;

   typedef struct packed {
      logic [7:0] init_word1;
      logic [4:0] vector_base;
      logic [7:0] cascade_word;
      logic [7:0] init_word4;
      logic [1:0] init_phase;
      logic       rotate_on_auto_eoi;
      logic       special_mask_mode;
      logic       read_in_service;
      logic       poll_pending;
      logic [2:0] lowest_priority;
      logic [7:0] mask_reg;
      logic [7:0] in_service;
      logic [7:0] requests;
      logic [7:0] level_mode;
      logic [7:0] notify_marks;
   } pic_state_type;

   pic_state_type state_ff;
   pic_state_type state_in;
   logic          is_secondary_ff;

   logic          slave_role;
   logic          aeoi;
   pic_scan_type  sc;
   pic_scan_type  eo;
   pic_scan_type  e0;
   pic_scan_type  fin;
   logic [7:0]    ack_bit;
   logic [7:0]    ack_isr;
   logic [7:0]    ack_req;
   logic [7:0]    ack_isr_done;
   logic [2:0]    ack_lp;
   logic [7:0]    ack_sweep;
   logic [7:0]    line_bit;
   logic [7:0]    icw1_iw4;
   logic          icw1_slave;
   logic [7:0]    sweep_req;
   logic          do_sweep;
   logic          do_ack;

   assign slave_role = state_ff.init_word4[INIT4_BUFFERED]
                       ? !state_ff.init_word4[INIT4_MASTER]
                       : is_secondary_ff;
   assign aeoi       = state_ff.init_word4[INIT4_AUTO_EOI];

   assign sc = prio_scan(state_ff.requests, state_ff.mask_reg, state_ff.in_service,
                         state_ff.cascade_word, state_ff.init_word4[INIT4_NESTED],
                         state_ff.special_mask_mode, state_ff.lowest_priority);

   // acknowledge of the winning level, with auto-EOI
   assign ack_bit = 8'b1 << sc.idx;
   assign ack_isr = state_ff.in_service | ack_bit;
   assign ack_req = (state_ff.level_mode & ack_bit) != 8'h00 ? state_ff.requests
                                                             : state_ff.requests & ~ack_bit;
   assign eo = first_hit(state_ff.special_mask_mode ? (ack_isr & state_ff.mask_reg)
                                                    : ack_isr,
                         state_ff.lowest_priority);
   assign ack_isr_done = (aeoi && eo.found) ? (ack_isr & ~(8'b1 << eo.idx)) : ack_isr;
   assign ack_lp       = (aeoi && state_ff.rotate_on_auto_eoi) ? sc.idx
                                                               : state_ff.lowest_priority;
   assign ack_sweep    = (aeoi && eo.found) ? ack_req : state_ff.requests;

   // non-specific EOI on the current state
   assign e0 = first_hit(state_ff.special_mask_mode
                            ? (state_ff.in_service & state_ff.mask_reg)
                            : state_ff.in_service,
                         state_ff.lowest_priority);

   assign line_bit   = 8'b1 << item.line;
   assign icw1_iw4   = item.wdata[INIT1_HAS_W4] ? state_ff.init_word4 : 8'h00;
   assign icw1_slave = icw1_iw4[INIT4_BUFFERED] ? !icw1_iw4[INIT4_MASTER] : is_secondary_ff;

   always_comb begin
      state_in  = state_ff;
      step_rsp  = '0;
      sweep_req = state_ff.requests;
      do_sweep  = 1'b0;
      do_ack    = 1'b0;

      unique case (item.op)
         OP_IO_READ: begin
            unique case (item.port_sel)
               PORT_ELCR: step_rsp.rdata = state_ff.level_mode;
               PORT_NONE: step_rsp.rdata = 8'h00;
               PORT_CMD, PORT_DATA: begin
                  priority if (state_ff.poll_pending) begin
                     state_in.poll_pending = 1'b0;
                     step_rsp.rdata        = {sc.found, 4'b0000, sc.idx};
                     do_sweep              = 1'b1;
                     if (sc.found) begin
                        state_in.in_service      = ack_isr_done;
                        state_in.requests        = ack_req;
                        state_in.lowest_priority = ack_lp;
                        sweep_req                = ack_sweep;
                     end
                  end else if (item.port_sel == PORT_CMD) begin
                     step_rsp.rdata = state_ff.read_in_service ? state_ff.in_service
                                                               : state_ff.requests;
                  end else begin
                     step_rsp.rdata = state_ff.mask_reg;
                  end
               end
            endcase
         end

         OP_IO_WRITE: begin
            unique case (item.port_sel)
               PORT_ELCR: state_in.level_mode = item.wdata;
               PORT_NONE: state_in = state_ff;
               PORT_CMD: begin
                  priority if (item.wdata[INIT1_START]) begin
                     state_in.init_word1        = item.wdata;
                     state_in.requests          = 8'h00;
                     state_in.mask_reg          = 8'h00;
                     state_in.lowest_priority   = 3'd7;
                     state_in.special_mask_mode = 1'b0;
                     state_in.read_in_service   = 1'b0;
                     state_in.init_word4        = icw1_iw4;
                     state_in.cascade_word      = icw1_slave ? 8'h07 : 8'h00;
                     state_in.in_service        = 8'h00;
                     state_in.poll_pending      = 1'b0;
                     state_in.level_mode        = item.wdata[INIT1_LEVEL] ? 8'hff : 8'h00;
                     state_in.notify_marks      = 8'h00;
                     state_in.init_phase        = PHASE_ICW2;
                  end else if (!item.wdata[OCW_SEL3]) begin
                     priority if (item.wdata[OCW2_SL]) begin
                        if (item.wdata[OCW2_EOI]) begin
                           state_in.in_service = state_ff.in_service
                                                 & ~(8'b1 << item.wdata[2:0]);
                           do_sweep = 1'b1;
                        end
                        if (item.wdata[OCW2_ROT]) begin
                           state_in.lowest_priority = item.wdata[2:0];
                        end
                     end else if (item.wdata[OCW2_EOI]) begin
                        if (e0.found) begin
                           state_in.in_service = state_ff.in_service & ~(8'b1 << e0.idx);
                           do_sweep = 1'b1;
                           if (item.wdata[OCW2_ROT]) begin
                              state_in.lowest_priority = e0.idx;
                           end
                        end
                     end else begin
                        state_in.rotate_on_auto_eoi = item.wdata[OCW2_ROT];
                     end
                  end else begin
                     if (item.wdata[OCW3_ESMM]) begin
                        state_in.special_mask_mode = item.wdata[OCW3_SMM];
                     end
                     if (item.wdata[OCW3_RR]) begin
                        state_in.read_in_service = item.wdata[OCW3_RIS];
                     end
                     state_in.poll_pending = item.wdata[OCW3_POLL];
                  end
               end
               PORT_DATA: begin
                  unique case (state_ff.init_phase)
                     PHASE_ICW2: begin
                        state_in.vector_base = item.wdata[7:3];
                        state_in.init_phase  = PHASE_ICW3;
                     end
                     PHASE_ICW3: begin
                        priority if (!state_ff.init_word1[INIT1_SINGLE]) begin
                           state_in.cascade_word = item.wdata;
                           state_in.init_phase   = PHASE_ICW4;
                        end else if (state_ff.init_word1[INIT1_HAS_W4]) begin
                           state_in.init_word4 = item.wdata;
                           state_in.init_phase = PHASE_MASK;
                        end else begin
                           state_in.mask_reg   = item.wdata;
                           state_in.init_phase = PHASE_MASK;
                           do_sweep            = 1'b1;
                        end
                     end
                     PHASE_ICW4: begin
                        state_in.init_phase = PHASE_MASK;
                        if (state_ff.init_word1[INIT1_HAS_W4]) begin
                           state_in.init_word4 = item.wdata;
                        end else begin
                           state_in.mask_reg = item.wdata;
                           do_sweep          = 1'b1;
                        end
                     end
                     PHASE_MASK: begin
                        state_in.mask_reg = item.wdata;
                        do_sweep          = 1'b1;
                     end
                  endcase
               end
            endcase
         end

         OP_LINE_ASSERT, OP_ASSERT_NOTIFY: begin
            if (item.op == OP_ASSERT_NOTIFY) begin
               state_in.notify_marks = state_ff.notify_marks | line_bit;
            end
            if ((state_ff.requests & line_bit) == 8'h00) begin
               state_in.requests = state_ff.requests | line_bit;
               sweep_req         = state_ff.requests | line_bit;
               do_sweep          = 1'b1;
            end
         end

         OP_LINE_DEASSERT: begin
            if ((state_ff.requests & state_ff.level_mode & line_bit) != 8'h00) begin
               state_in.requests = state_ff.requests & ~line_bit;
               sweep_req         = state_ff.requests & ~line_bit;
               do_sweep          = 1'b1;
            end
         end

         OP_CPU_ACK: do_ack = 1'b1;

         OP_CASCADE_ACK: begin
            if (slave_role && item.cascade_id == state_ff.cascade_word[2:0]) begin
               step_rsp.handled = 1'b1;
               do_ack           = 1'b1;
            end
         end

         OP_NONE: state_in = state_ff;
      endcase

      if (do_ack) begin
         do_sweep       = 1'b1;
         step_rsp.rdata = {state_ff.vector_base, sc.found ? sc.idx : 3'd7};
         if (sc.found) begin
            state_in.in_service      = ack_isr_done;
            state_in.requests        = ack_req;
            state_in.lowest_priority = ack_lp;
            sweep_req                = ack_req;
            if (!slave_role && state_ff.cascade_word[sc.idx]) begin
               step_rsp.cascade_request = 1'b1;
               step_rsp.cascade_line    = sc.idx;
            end
         end
      end

      // notify marks whose request has dropped
      if (do_sweep) begin
         step_rsp.notify_bits  = state_in.notify_marks & ~sweep_req;
         state_in.notify_marks = state_in.notify_marks & sweep_req;
      end

      fin = prio_scan(state_in.requests, state_in.mask_reg, state_in.in_service,
                      state_in.cascade_word, state_in.init_word4[INIT4_NESTED],
                      state_in.special_mask_mode, state_in.lowest_priority);
      step_rsp.int_level = fin.found;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                 <= '0;
         state_ff.lowest_priority <= 3'd7;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_secondary_ff <= 1'b0;
      end else if (csr_write) begin
         is_secondary_ff <= csr_wdata;
      end
   end

`ifndef NO_ASSERTIONS
   a_icw1_restart: assert property (@(posedge clock) disable iff (reset)
      step_en && item.op == OP_IO_WRITE && item.port_sel == PORT_CMD
      && item.wdata[INIT1_START]
      |=> state_ff.init_phase == PHASE_ICW2 && state_ff.in_service == 8'h00)
      else $error("ICW1 did not restart initialisation");

   a_notify_subset: assert property (@(posedge clock) disable iff (reset)
      step_en |-> (step_rsp.notify_bits & ~state_ff.notify_marks) == 8'h00)
      else $error("notify bit reported without a mark");

   a_cascade_role: assert property (@(posedge clock) disable iff (reset)
      step_en && step_rsp.cascade_request |-> !slave_role && !step_rsp.handled)
      else $error("cascade request raised in slave role");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> state_ff == $past(state_ff))
      else $error("state changed without a request");
`endif

endmodule

### src/pic_out_stage.sv
// ----------------------------------------------------------------------------
// pic_out_stage
// Result register driving the response channel.
// ----------------------------------------------------------------------------
module pic_out_stage
   import pic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  pic_rsp_type result,
   output logic        can_load,
   output logic        m_valid,
   input  logic        m_ready,
   output pic_rsp_type m_result
);

   logic        valid_ff;
   logic        valid_in;
   pic_rsp_type result_ff;

   assign can_load = !valid_ff || m_ready;
   assign valid_in = load ? 1'b1 : (m_ready ? 1'b0 : valid_ff);
   assign m_valid  = valid_ff;
   assign m_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

### src/programmable_interrupt_controller.sv
// ----------------------------------------------------------------------------
// programmable_interrupt_controller
// 8259A-style interrupt controller with edge/level register and notify marks.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata, req_tuser
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tuser
//  csr     | in  | csr_valid/csr_ready   | csr_wdata (is_secondary)
//
//  One request per cycle unless rsp stalls; responses pass the input and result registers.
//  Each request is resolved in one pass through the 8-way rotating priority
//  scan between the input register and the result register.
//  Reset is synchronous; no clearing pass.
//  A stalled response holds; the input register takes one more request.
//  csr_ready is always high.
// ----------------------------------------------------------------------------
module programmable_interrupt_controller
   import pic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // wdata[7:0], line[10:8], cascade_id[13:11]
   input  logic [4:0]  req_tuser,   // op[2:0], port_sel[4:3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // rdata[7:0], int_level[8], cascade_line[11:9],
                                    // notify_bits[19:12]
   output logic [1:0]  rsp_tuser,   // handled[0], cascade_request[1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata
);

   pic_req_type s_item;
   pic_req_type cur_item;
   pic_rsp_type step_rsp;
   pic_rsp_type rsp_item;
   logic        cur_valid;
   logic        can_load;
   logic        step_en;

   assign s_item.op         = req_tuser[2:0];
   assign s_item.port_sel   = req_tuser[4:3];
   assign s_item.wdata      = req_tdata[7:0];
   assign s_item.line       = req_tdata[10:8];
   assign s_item.cascade_id = req_tdata[13:11];

   assign csr_ready = 1'b1;
   assign step_en   = cur_valid && can_load;

   pic_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .s_valid (req_tvalid),
      .s_ready (req_tready),
      .s_item  (s_item),
      .advance (step_en),
      .m_valid (cur_valid),
      .m_item  (cur_item)
   );

   pic_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .step_en   (step_en),
      .item      (cur_item),
      .step_rsp  (step_rsp)
   );

   pic_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (step_en),
      .result   (step_rsp),
      .can_load (can_load),
      .m_valid  (rsp_tvalid),
      .m_ready  (rsp_tready),
      .m_result (rsp_item)
   );

   assign rsp_tdata = {4'b0000, rsp_item.notify_bits, rsp_item.cascade_line,
                       rsp_item.int_level, rsp_item.rdata};
   assign rsp_tuser = {rsp_item.cascade_request, rsp_item.handled};

endmodule

### tb/sv/pic_response_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pic_response_check
// Watches the request, response and csr channels of the interrupt controller.
// It keeps its own copy of the controller state and works out the response for
// each accepted request. Each response is compared field by field with the
// oldest one still waiting. The number of failures and the number of
// responses still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module pic_response_check
   import pic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [4:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_wdata,
   output int          outstanding,
   output int          errors
);

   // init word sequence position
   localparam logic [1:0] PH_MASK = 2'd0;
   localparam logic [1:0] PH_ICW2 = 2'd1;
   localparam logic [1:0] PH_ICW3 = 2'd2;
   localparam logic [1:0] PH_ICW4 = 2'd3;

   logic       secondary;
   logic [7:0] icw1, icw3, icw4;
   logic [4:0] vbase;
   logic [1:0] phase;
   logic       rot_aeoi, smm, ris, poll;
   logic [2:0] lowest;
   logic [7:0] imr, isr, irr, elcr, marks, cleared;

   pic_rsp_type expected_rsps[$];
   int          fails = 0;

   function automatic logic slave_mode();
      if (icw4[INIT4_BUFFERED]) return !icw4[INIT4_MASTER];
      return secondary;
   endfunction

   // notify marks drop once their request bit is low
   function automatic void sweep_marks();
      logic [7:0] t;
      t       = ~irr & marks;
      marks   = marks & ~t;
      cleared = cleared | t;
   endfunction

   function automatic pic_scan_type resolve(input logic [7:0] pend);
      pic_scan_type s;
      logic [2:0]   lv;
      logic         stop;
      s.found = 1'b0;
      s.idx   = lowest;
      stop    = 1'b0;
      for (int i = 0; i < 8; i++) begin
         lv = lowest + 3'(i + 1);
         if (!stop) begin
            if (!smm && isr[lv] && !(icw4[INIT4_NESTED] && icw3[lv])) begin
               stop  = 1'b1;
               s.idx = lv;
            end else if (pend[lv]) begin
               stop    = 1'b1;
               s.found = 1'b1;
               s.idx   = lv;
            end
         end
      end
      return s;
   endfunction

   // clears the highest eligible in-service level; level+1 or 0
   function automatic logic [3:0] eoi_highest();
      logic [2:0] lv;
      logic [3:0] res;
      res = 4'd0;
      for (int i = 0; i < 8; i++) begin
         lv = lowest + 3'(i + 1);
         if (res == 4'd0 && isr[lv] && !(smm && !imr[lv])) begin
            isr[lv] = 1'b0;
            sweep_marks();
            res = {1'b0, lv} + 4'd1;
         end
      end
      return res;
   endfunction

   function automatic pic_scan_type take_level();
      pic_scan_type s;
      logic [7:0]   pend;
      pend = irr & ~imr;
      sweep_marks();
      s = resolve(pend);
      if (s.found) begin
         isr[s.idx] = 1'b1;
         if (!elcr[s.idx]) irr[s.idx] = 1'b0;
         if (icw4[INIT4_AUTO_EOI]) begin
            void'(eoi_highest());
            if (rot_aeoi) lowest = s.idx;
         end
      end
      return s;
   endfunction

   function automatic logic [7:0] ack_vector(output logic creq, output logic [2:0] cline);
      pic_scan_type s;
      s     = take_level();
      creq  = 1'b0;
      cline = 3'd0;
      if (s.found) begin
         if (!slave_mode() && icw3[s.idx]) begin
            creq  = 1'b1;
            cline = s.idx;
         end
      end else begin
         s.idx = 3'd7;
      end
      return {vbase, s.idx};
   endfunction

   function automatic void init_reset();
      irr    = 8'h00;
      imr    = 8'h00;
      lowest = 3'd7;
      smm    = 1'b0;
      ris    = 1'b0;
      if (!icw1[INIT1_HAS_W4]) icw4 = 8'h00;
      icw3   = slave_mode() ? 8'h07 : 8'h00;
      isr    = 8'h00;
      poll   = 1'b0;
      elcr   = icw1[INIT1_LEVEL] ? 8'hFF : 8'h00;
      marks  = 8'h00;
      sweep_marks();
   endfunction

   function automatic void model_reset();
      secondary = 1'b0;
      icw1      = 8'h00;
      vbase     = 5'd0;
      icw4      = 8'h00;
      phase     = PH_MASK;
      rot_aeoi  = 1'b0;
      init_reset();
      cleared   = 8'h00;
   endfunction

   function automatic pic_rsp_type predict_response(input pic_req_type r);
      pic_rsp_type  o;
      pic_scan_type s;
      logic [7:0]   w;
      logic [7:0]   bitm;
      logic [3:0]   lv;
      o       = '0;
      w       = r.wdata;
      bitm    = 8'h01 << r.line;
      cleared = 8'h00;
      case (r.op)
         OP_IO_READ: begin
            if (r.port_sel == PORT_ELCR) o.rdata = elcr;
            else if (r.port_sel == PORT_NONE) o.rdata = 8'h00;
            else if (poll) begin
               poll    = 1'b0;
               s       = take_level();
               o.rdata = {s.found, 4'b0000, s.idx};
            end else if (r.port_sel == PORT_CMD) o.rdata = ris ? isr : irr;
            else o.rdata = imr;
         end
         OP_IO_WRITE: begin
            case (r.port_sel)
               PORT_ELCR: elcr = w;
               PORT_CMD: begin
                  if (w[INIT1_START]) begin
                     icw1 = w;
                     init_reset();
                     phase = PH_ICW2;
                  end else if (!w[OCW_SEL3]) begin
                     if (w[OCW2_SL]) begin
                        if (w[OCW2_EOI]) begin
                           isr[w[2:0]] = 1'b0;
                           sweep_marks();
                        end
                        if (w[OCW2_ROT]) lowest = w[2:0];
                     end else if (w[OCW2_EOI]) begin
                        lv = eoi_highest();
                        if (w[OCW2_ROT] && lv != 4'd0) lowest = 3'(lv - 4'd1);
                     end else begin
                        rot_aeoi = w[OCW2_ROT];
                     end
                  end else begin
                     if (w[OCW3_ESMM]) smm = w[OCW3_SMM];
                     if (w[OCW3_RR]) ris = w[OCW3_RIS];
                     poll = w[OCW3_POLL];
                  end
               end
               PORT_DATA: begin
                  if (phase == PH_ICW2) begin
                     vbase = w[7:3];
                     phase = PH_ICW3;
                  end else if (phase == PH_ICW3 && !icw1[INIT1_SINGLE]) begin
                     phase = PH_ICW4;
                     icw3  = w;
                  end else if (phase != PH_MASK && icw1[INIT1_HAS_W4]) begin
                     phase = PH_MASK;
                     icw4  = w;
                  end else begin
                     phase = PH_MASK;
                     imr   = w;
                     sweep_marks();
                  end
               end
               default: ;
            endcase
         end
         OP_LINE_ASSERT, OP_ASSERT_NOTIFY: begin
            if (r.op == OP_ASSERT_NOTIFY) marks = marks | bitm;
            if ((irr & bitm) == 8'h00) begin
               irr = irr | bitm;
               sweep_marks();
            end
         end
         OP_LINE_DEASSERT: begin
            if ((irr & bitm) != 8'h00 && (elcr & bitm) != 8'h00) begin
               irr = irr & ~bitm;
               sweep_marks();
            end
         end
         OP_CPU_ACK: begin
            o.rdata = ack_vector(o.cascade_request, o.cascade_line);
            sweep_marks();
         end
         OP_CASCADE_ACK: begin
            if (slave_mode() && r.cascade_id == icw3[2:0]) begin
               o.handled = 1'b1;
               o.rdata   = ack_vector(o.cascade_request, o.cascade_line);
               sweep_marks();
            end
         end
         default: ;
      endcase
      o.int_level   = resolve(irr & ~imr).found;
      o.notify_bits = cleared;
      return o;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned seen);
      if (want != seen) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
         fails++;
      end
   endtask

   always @(posedge clock) begin : watch
      pic_req_type r;
      pic_rsp_type got;
      pic_rsp_type want;
      if (reset) begin
         model_reset();
         expected_rsps.delete();
      end else begin
         if (csr_valid && csr_ready) secondary = csr_wdata;
         if (req_tvalid && req_tready) begin
            r.wdata      = req_tdata[7:0];
            r.line       = req_tdata[10:8];
            r.cascade_id = req_tdata[13:11];
            r.op         = req_tuser[2:0];
            r.port_sel   = req_tuser[4:3];
            expected_rsps.push_back(predict_response(r));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.rdata           = rsp_tdata[7:0];
            got.int_level       = rsp_tdata[8];
            got.cascade_line    = rsp_tdata[11:9];
            got.notify_bits     = rsp_tdata[19:12];
            got.handled         = rsp_tuser[0];
            got.cascade_request = rsp_tuser[1];
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with none expected, got %0h", $time, got);
               fails++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("rdata", want.rdata, got.rdata);
               check_field("handled", want.handled, got.handled);
               check_field("int_level", want.int_level, got.int_level);
               check_field("cascade_request", want.cascade_request, got.cascade_request);
               check_field("cascade_line", want.cascade_line, got.cascade_line);
               check_field("notify_bits", want.notify_bits, got.notify_bits);
            end
         end
      end
      outstanding <= expected_rsps.size();
      errors      <= fails;
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the interrupt controller with a directed opening (port reads, init
// words, cascaded and spurious acks, poll, EOI forms, notify marks) and then
// random bus accesses, line events and acks under both secondary settings.
// Both channels idle at random; the response side also holds off for a long
// stretch. Checking is done by pic_response_check.
// ----------------------------------------------------------------------------
module tb;
   import pic_pkg::*;

   localparam int PHASE_ITEMS = 350;
   localparam int HOLD_CYCLES = 150;
   localparam int TAIL_CYCLES = 8;
   localparam int CYCLE_LIMIT = 100000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [4:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_wdata;

   int   outstanding;
   int   errors;
   int   items_sent  = 0;
   int   cycle_count = 0;
   int   hold_trips  = 0;
   int   hold_seen   = 0;
   int   hold_left   = 0;
   logic steady      = 1'b0;

   programmable_interrupt_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   pic_response_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .errors      (errors)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side: random idling, steady stretch, long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_seen != hold_trips) begin
         hold_seen  <= hold_trips;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 19);
      end
   end

   task automatic send_request(input pic_req_type r);
      while (!steady && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.cascade_id, r.line, r.wdata};
      req_tuser  <= {r.port_sel, r.op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_op(input logic [2:0] op, input logic [1:0] port,
                          input logic [7:0] data, input logic [2:0] ln = 3'd0,
                          input logic [2:0] cid = 3'd0);
      pic_req_type r;
      r.op         = op;
      r.port_sel   = port;
      r.wdata      = data;
      r.line       = ln;
      r.cascade_id = cid;
      send_request(r);
   endtask

   function automatic pic_req_type rand_fields();
      pic_req_type r;
      r.op         = 3'($urandom_range(0, 7));
      r.port_sel   = 2'($urandom_range(0, 3));
      r.wdata      = 8'($urandom);
      r.line       = 3'($urandom_range(0, 7));
      r.cascade_id = 3'($urandom_range(0, 7));
      return r;
   endfunction

   task automatic send_random();
      pic_req_type r;
      int          pick;
      r    = rand_fields();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         // full init word sequence with random content
         r.op       = OP_IO_WRITE;
         r.port_sel = PORT_CMD;
         r.wdata    = r.wdata | 8'h10;
         send_request(r);
         repeat (3) begin
            r          = rand_fields();
            r.op       = OP_IO_WRITE;
            r.port_sel = PORT_DATA;
            send_request(r);
         end
      end else begin
         if (pick < 29) r.op = ($urandom_range(0, 1) != 0) ? OP_ASSERT_NOTIFY : OP_LINE_ASSERT;
         else if (pick < 39) r.op = OP_LINE_DEASSERT;
         else if (pick < 53) r.op = OP_CPU_ACK;
         else if (pick < 61) r.op = OP_CASCADE_ACK;
         else if (pick < 71) r.op = OP_IO_READ;
         else if (pick < 80) begin
            r.op       = OP_IO_WRITE;
            r.port_sel = PORT_CMD;
            r.wdata    = r.wdata & 8'hE7;
         end else if (pick < 87) begin
            r.op       = OP_IO_WRITE;
            r.port_sel = PORT_CMD;
            r.wdata    = (r.wdata & 8'hEF) | 8'h08;
         end else if (pick < 93) begin
            r.op       = OP_IO_WRITE;
            r.port_sel = PORT_DATA;
         end else if (pick < 97) begin
            r.op       = OP_IO_WRITE;
            r.port_sel = PORT_ELCR;
         end
         send_request(r);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_secondary(input logic value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int   phase_start;
      logic held;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_wdata  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_op(OP_IO_READ, PORT_CMD, 8'h00);
      send_op(OP_IO_READ, PORT_NONE, 8'h00);
      send_op(OP_NONE, PORT_NONE, 8'hFF, 3'd7, 3'd7);
      send_op(OP_IO_WRITE, PORT_NONE, 8'hFF);
      send_op(OP_CPU_ACK, PORT_CMD, 8'h00);             // spurious
      send_op(OP_IO_WRITE, PORT_CMD, 8'h11);            // init, cascaded, edge
      send_op(OP_IO_WRITE, PORT_DATA, 8'hF8);           // top vector base
      send_op(OP_IO_WRITE, PORT_DATA, 8'h80);           // slave on line 7
      send_op(OP_IO_WRITE, PORT_DATA, 8'h01);
      send_op(OP_LINE_ASSERT, PORT_CMD, 8'h00, 3'd7);
      send_op(OP_CPU_ACK, PORT_CMD, 8'h00);             // cascaded line
      send_op(OP_ASSERT_NOTIFY, PORT_CMD, 8'h00, 3'd0);
      send_op(OP_CPU_ACK, PORT_CMD, 8'h00);             // clears the notify mark
      send_op(OP_IO_WRITE, PORT_CMD, 8'hA0);            // rotating non-specific EOI
      send_op(OP_IO_WRITE, PORT_CMD, 8'h67);            // specific EOI
      send_op(OP_IO_WRITE, PORT_CMD, 8'h0C);            // poll
      send_op(OP_IO_READ, PORT_CMD, 8'h00);             // poll with nothing pending
      send_op(OP_IO_WRITE, PORT_CMD, 8'h68);            // special mask mode
      send_op(OP_IO_WRITE, PORT_CMD, 8'h0B);            // read ISR
      send_op(OP_IO_READ, PORT_CMD, 8'h00);
      send_op(OP_IO_WRITE, PORT_CMD, 8'h80);            // rotate on auto-EOI
      send_op(OP_IO_WRITE, PORT_ELCR, 8'hFF);
      send_op(OP_LINE_ASSERT, PORT_CMD, 8'h00, 3'd3);
      send_op(OP_LINE_DEASSERT, PORT_CMD, 8'h00, 3'd3);
      send_op(OP_CASCADE_ACK, PORT_CMD, 8'h00, 3'd0, 3'd0);

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         write_secondary((ph % 2) == 0);
         steady      <= (ph == 2);
         phase_start = items_sent;
         held        = 1'b0;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (ph == 1 && !held && items_sent - phase_start >= 100) begin
               hold_trips <= hold_trips + 1;
               held = 1'b1;
            end
            send_random();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
